// ===== sv/assert_macros.svh =====
// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition implies a property at the same edge
`define ASSERT_IMPLY(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// condition implies a property at the next edge
`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/brbf_pkg.sv =====
`timescale 1ns / 1ps
package brbf_pkg;

  localparam int LEN_W          = 7;
  localparam int DATA_W         = 16;
  localparam int TDATA_IN_W     = 24;
  localparam int TDATA_OUT_W    = 24;
  localparam int OUT_PAD_W      = TDATA_OUT_W - DATA_W - 1;
  localparam int DEPTH_DEF      = 64;
  localparam int ELEM_WIDTH_DEF = 16;

  // request kinds carried in tuser
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic              status;
    logic              has_data;
    logic [DATA_W-1:0] elem_out;
    logic              run_last;
  } res_t;

endpackage

// ===== sv/block_ring_buffer_fifo_core.sv =====
`timescale 1ns / 1ps
// push: an accepted word is written unless its block is dropped or the memory is full; a last
// word queues a status word. pop of n words: the sequencer enters the pop state, then reads one
// entry a cycle while the output queue has room; each read word is registered, then queued, and
// the input is held until the last one is queued. pushes: one word a cycle while the output queue is not full
// reset: asynchronous, active low; clears pointers, fill level, block flags and output queue
// element memory is not cleared: only entries counted in the fill level are ever read
`include "assert_macros.svh"

module block_ring_buffer_fifo_core
  import brbf_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // block_len[6:0], elem_in[22:7], zero pad
  input  logic                   s_axis_tlast,   // elem_last
  input  logic                   s_axis_tuser,   // func
  // result side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // status[0], elem_out[16:1], zero pad
  output logic                   m_axis_tlast,   // run_last
  output logic                   m_axis_tuser    // has_data
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);
  localparam logic [SUM_W-1:0]  SUM_DEPTH = SUM_W'(DEPTH);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  // request fields
  logic              s_acc;
  logic [LEN_W-1:0]  s_len;
  logic [DATA_W-1:0] s_elem;

  assign s_len  = s_axis_tdata[LEN_W-1:0];
  assign s_elem = s_axis_tdata[LEN_W+DATA_W-1:LEN_W];

  // control state
  logic              st_q, st_d;
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              open_q, open_d;
  logic              dropped_q, dropped_d;
  logic [LEN_W-1:0]  remain_q, remain_d;
  logic              rd_pend_q;
  logic              rd_last_q;

  // element memory, one write or one read per cycle
  logic [ELEM_WIDTH-1:0] mem_q [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_data_q;
  logic                  mem_we;
  logic                  rd_issue;

  // write address: read pointer plus fill level, wrapped
  logic [SUM_W-1:0] wp_sum;
  logic [PTR_W-1:0] wp;
  logic [FILL_W-1:0] free_cnt;

  assign wp_sum   = SUM_W'(rp_q) + SUM_W'(fill_q);
  assign wp       = (wp_sum >= SUM_DEPTH) ? PTR_W'(wp_sum - SUM_DEPTH) : PTR_W'(wp_sum);
  assign free_cnt = FILL_FULL - fill_q;

  // two-word output queue
  res_t       buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       deq;
  logic       enq;
  res_t       enq_res;
  logic       item_enq;
  res_t       item_res;
  logic [1:0] occ;
  logic       room;

  assign deq  = m_axis_tvalid && m_axis_tready;
  // words held after this edge, counting a read still in flight
  assign occ  = cnt_q + {1'b0, rd_pend_q} - {1'b0, deq};
  assign room = !occ[1];

  assign s_axis_tready = (st_q == ST_IDLE) && (cnt_q != 2'd2);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic drop_now;
    drop_now  = 1'b0;
    st_d      = st_q;
    rp_d      = rp_q;
    fill_d    = fill_q;
    open_d    = open_q;
    dropped_d = dropped_q;
    remain_d  = remain_q;
    mem_we    = 1'b0;
    rd_issue  = 1'b0;
    item_enq  = 1'b0;
    item_res  = '0;
    case (st_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser == FUNC_PUSH) begin
            // space check only on the first word of a block
            drop_now = open_q ? dropped_q : (s_len > LEN_W'(free_cnt));
            if (!drop_now && (fill_q != FILL_FULL)) begin
              mem_we = 1'b1;
              fill_d = fill_q + FILL_W'(1);
            end
            if (s_axis_tlast) begin
              item_enq          = 1'b1;
              item_res.status   = drop_now;
              item_res.run_last = 1'b1;
              open_d            = 1'b0;
              dropped_d         = 1'b0;
            end else begin
              open_d    = 1'b1;
              dropped_d = drop_now;
            end
          end else begin
            if (s_len > LEN_W'(fill_q)) begin
              item_enq          = 1'b1;
              item_res.status   = 1'b1;
              item_res.run_last = 1'b1;
            end else if (s_len == '0) begin
              item_enq          = 1'b1;
              item_res.run_last = 1'b1;
            end else begin
              st_d     = ST_POP;
              remain_d = s_len;
            end
          end
        end
      end
      ST_POP: begin
        if ((remain_q != '0) && room) begin
          rd_issue = 1'b1;
          rp_d     = (rp_q == PTR_LAST) ? '0 : rp_q + PTR_W'(1);
          fill_d   = fill_q - FILL_W'(1);
          remain_d = remain_q - LEN_W'(1);
        end
        // final read data lands this cycle
        if ((remain_q == '0) && rd_pend_q) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      rp_q      <= '0;
      fill_q    <= '0;
      open_q    <= 1'b0;
      dropped_q <= 1'b0;
      remain_q  <= '0;
      rd_pend_q <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      rp_q      <= rp_d;
      fill_q    <= fill_d;
      open_q    <= open_d;
      dropped_q <= dropped_d;
      remain_q  <= remain_d;
      rd_pend_q <= rd_issue;
      rd_last_q <= rd_issue && (remain_q == LEN_W'(1));
    end
  end

  // pushes and pops never overlap, so no forwarding between write and read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp] <= ELEM_WIDTH'(s_elem);
    end
    if (rd_issue) begin
      rd_data_q <= mem_q[rp_q];
    end
  end

  // queue input: memory data while popping, else the status word of the request
  always_comb begin
    enq     = item_enq || rd_pend_q;
    enq_res = item_res;
    if (rd_pend_q) begin
      enq_res.status   = 1'b0;
      enq_res.has_data = 1'b1;
      enq_res.elem_out = DATA_W'(rd_data_q);
      enq_res.run_last = rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (enq) begin
        wptr_q <= !wptr_q;
      end
      if (deq) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      buf_q[wptr_q] <= enq_res;
    end
  end

  res_t head;
  assign head          = buf_q[rptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, head.elem_out, head.status};
  assign m_axis_tlast  = head.run_last;
  assign m_axis_tuser  = head.has_data;

  `ASSERT_IMPLY(a_no_overflow, cnt_q == 2'd2 && !deq, !enq, "output queue overflow")
  `ASSERT_IMPLY(a_read_has_data, rd_issue, fill_q != '0, "read issued on empty fifo")
  `ASSERT_IMPLY(a_idle_no_read, s_acc, !rd_pend_q, "request taken while read in flight")
  `ASSERT_NEXT(a_pop_ends, st_q == ST_POP && rd_pend_q && rd_last_q, st_q == ST_IDLE, "pop did not end")
  `ASSERT_NEXT(a_idle_stable, st_q == ST_IDLE && !s_acc, $stable(fill_q) && $stable(rp_q), "state moved while idle")

endmodule
